### hdl/tsc_pkg.sv
// Shared widths and fixed-point constants for the Taylor-series sine/cosine pipeline.
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

  // Series length used when the top level is not told otherwise
  localparam int TERMS_DEFAULT = 8;

  // Port widths: angle is Q8.24, value is Q2.30
  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;

  // Reduction datapath: |angle| in Q.32 and the quotient by pi
  localparam int MAG_W       = 40;
  localparam int REM_W       = 34;
  localparam int Q_W         = 6;
  localparam int DIV_STAGES  = Q_W / 2;

  // Series datapath
  localparam int Q30_SHIFT   = 30;
  localparam int X_W         = 32;
  localparam int SQ_W        = 34;
  localparam int SQ_LO_W     = 17;
  localparam int SQ_HI_W     = SQ_W - SQ_LO_W;
  localparam int TERM_W      = 35;
  localparam int N_W         = 38;
  localparam int SUM_W       = 40;

  // Reciprocal used for the exact division by 2i(2i-1)
  localparam int RECIP_W     = 48;
  localparam int RECIP_SHIFT = 48;
  localparam int RECIP_LO_W  = 24;
  localparam int RECIP_HI_W  = RECIP_W - RECIP_LO_W;

  // pi in Q.32 truncated, and pi/2 in Q8.24 rounded to nearest
  localparam logic [REM_W-1:0]          PI_Q32      = 34'd13493037704;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24 = 32'sd26353589;

  // 1.0 in Q.30
  localparam logic [TERM_W-1:0] ONE_Q30 = TERM_W'(1) << Q30_SHIFT;

endpackage

`default_nettype wire

### hdl/taylor_sine_cosine.sv
// Fully pipelined fixed-point cosine/sine evaluated by a truncated Taylor series.
`timescale 1ns / 1ps
`default_nettype none

// Evaluates cos(angle) (operation = 0) or sin(angle) (operation = 1) for a signed Q8.24
// angle and returns a signed Q2.30 value. A new item may be started on every clock
// cycle; busy is high only while rst is held. Each item's result appears on value with
// a one-cycle done strobe. Results come out in the order the items went in and
// cannot be held off, so the receiver must take value on the cycle done is high. Most
// of the pipeline is the series: every term passes through four stages (a split
// term-by-x^2 product, its rounding, a split reciprocal product and its shift for the
// exact division by 2i(2i-1)); the angle reduction adds a three-stage restoring divide
// by pi, one quotient bit pair per stage.
module taylor_sine_cosine #(
  parameter int TERMS = tsc_pkg::TERMS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               operation,
  input  logic signed [tsc_pkg::ANGLE_W-1:0] angle,
  output logic                               busy,
  output logic                               done,
  output logic signed [tsc_pkg::VALUE_W-1:0] value
);

  import tsc_pkg::*;

  localparam int LATENCY = 11 + 4 * TERMS;
  localparam int PP_W    = TERM_W + SQ_LO_W;
  localparam int PROD_W  = TERM_W + SQ_W + 1;
  localparam int RPP_W   = N_W + RECIP_LO_W;
  localparam int RPROD_W = N_W + RECIP_W + 1;
  localparam int XPROD_W = 2 * X_W;
  localparam bit LAST_SUB = (TERMS % 2) == 1;

  logic accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // Input register
  logic                      in_vld;
  logic                      in_op;
  logic signed [ANGLE_W-1:0] in_ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= accept;
    end
    in_op  <= operation;
    in_ang <= angle;
  end

  // Sine argument pi/2 - angle, saturated to Q8.24
  logic signed [ANGLE_W:0]   arg_diff;
  logic signed [ANGLE_W-1:0] arg_sat;
  logic                      s1_vld;
  logic signed [ANGLE_W-1:0] s1_ang;

  always_comb begin
    arg_diff = {HALF_PI_Q24[ANGLE_W-1], HALF_PI_Q24} - {in_ang[ANGLE_W-1], in_ang};
    if (arg_diff[ANGLE_W] != arg_diff[ANGLE_W-1]) begin
      arg_sat = arg_diff[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
    end else begin
      arg_sat = arg_diff[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
    end
    s1_ang <= in_op ? arg_sat : in_ang;
  end

  // Magnitude of the angle in Q.32; only the quotient parity keeps the sign's effect
  logic [ANGLE_W-1:0] ang_bits;
  logic [ANGLE_W-1:0] ang_abs;

  assign ang_bits = s1_ang;
  assign ang_abs  = ang_bits[ANGLE_W-1] ? (~ang_bits + ANGLE_W'(1)) : ang_bits;

  logic             dv_vld [0:DIV_STAGES];
  logic [MAG_W-1:0] dv_rem [0:DIV_STAGES];
  logic [Q_W-1:0]   dv_q   [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= s1_vld;
    end
    dv_rem[0] <= {ang_abs, (MAG_W-ANGLE_W)'(0)};
    dv_q[0]   <= '0;
  end

  // Restoring divide by pi, two quotient bits per stage
  for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
    localparam int BIT_A = Q_W - 1 - 2 * d;
    localparam int BIT_B = BIT_A - 1;
    localparam logic [MAG_W-1:0] DIV_A = MAG_W'(PI_Q32) << BIT_A;
    localparam logic [MAG_W-1:0] DIV_B = MAG_W'(PI_Q32) << BIT_B;

    logic [MAG_W-1:0] rem_a;
    logic [MAG_W-1:0] rem_b;
    logic [Q_W-1:0]   q_n;

    always_comb begin
      q_n   = dv_q[d];
      rem_a = dv_rem[d];
      if (dv_rem[d] >= DIV_A) begin
        rem_a      = dv_rem[d] - DIV_A;
        q_n[BIT_A] = 1'b1;
      end
      rem_b = rem_a;
      if (rem_a >= DIV_B) begin
        rem_b      = rem_a - DIV_B;
        q_n[BIT_B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[d+1] <= 1'b0;
      end else begin
        dv_vld[d+1] <= dv_vld[d];
      end
      dv_rem[d+1] <= rem_b;
      dv_q[d+1]   <= q_n;
    end
  end

  // Reduced angle rounded to Q.30
  logic [REM_W:0] x_round;
  logic           x_vld;
  logic [X_W-1:0] x_val;
  logic           x_odd;

  assign x_round = {1'b0, dv_rem[DIV_STAGES][REM_W-1:0]} + (REM_W+1)'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld <= 1'b0;
    end else begin
      x_vld <= dv_vld[DIV_STAGES];
    end
    x_val <= x_round[X_W+1:2];
    x_odd <= dv_q[DIV_STAGES][0];
  end

  // x^2: full product, then rounding to Q.30
  logic               p_vld;
  logic [XPROD_W-1:0] p_prod;
  logic               p_odd;
  logic [XPROD_W:0]   p_round;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= x_vld;
    end
    p_prod <= XPROD_W'(x_val) * XPROD_W'(x_val);
    p_odd  <= x_odd;
  end

  assign p_round = {1'b0, p_prod} + ((XPROD_W+1)'(1) << (Q30_SHIFT - 1));

  // Boundaries between series terms; slot 0 holds 1.0 with an empty sum
  logic                    tm_vld  [0:TERMS];
  logic [TERM_W-1:0]       tm_term [0:TERMS];
  logic signed [SUM_W-1:0] tm_sum  [0:TERMS];
  logic [SQ_W-1:0]         tm_sq   [0:TERMS];
  logic                    tm_odd  [0:TERMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      tm_vld[0] <= 1'b0;
    end else begin
      tm_vld[0] <= p_vld;
    end
    tm_term[0] <= ONE_Q30;
    tm_sum[0]  <= '0;
    tm_sq[0]   <= p_round[Q30_SHIFT +: SQ_W];
    tm_odd[0]  <= p_odd;
  end

  // One series term per four stages
  for (genvar g = 0; g < TERMS; g++) begin : g_term
    localparam int          IDX      = g + 1;
    localparam logic [63:0] DEN      = 64'(2 * IDX * (2 * IDX - 1));
    localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + DEN - 64'd1) / DEN);
    localparam bit          PREV_SUB = (g % 2) == 1;

    logic                    a_vld;
    logic [PP_W-1:0]         a_pp_lo;
    logic [PP_W-1:0]         a_pp_hi;
    logic signed [SUM_W-1:0] a_sum;
    logic [SQ_W-1:0]         a_sq;
    logic                    a_odd;
    logic signed [SUM_W-1:0] term_ext;

    logic                    b_vld;
    logic [N_W-1:0]          b_n;
    logic signed [SUM_W-1:0] b_sum;
    logic [SQ_W-1:0]         b_sq;
    logic                    b_odd;
    logic [PROD_W-1:0]       prod;

    logic                    c_vld;
    logic [RPP_W-1:0]        c_pp_lo;
    logic [RPP_W-1:0]        c_pp_hi;
    logic signed [SUM_W-1:0] c_sum;
    logic [SQ_W-1:0]         c_sq;
    logic                    c_odd;
    logic [RPROD_W-1:0]      rprod;

    assign term_ext = $signed({{(SUM_W-TERM_W){1'b0}}, tm_term[g]});

    // Stage A: term times x^2 in two halves; the previous term joins the sum
    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld <= 1'b0;
      end else begin
        a_vld <= tm_vld[g];
      end
      a_pp_lo <= PP_W'(tm_term[g]) * PP_W'(tm_sq[g][SQ_LO_W-1:0]);
      a_pp_hi <= PP_W'(tm_term[g]) * PP_W'(tm_sq[g][SQ_W-1:SQ_LO_W]);
      a_sum   <= PREV_SUB ? (tm_sum[g] - term_ext) : (tm_sum[g] + term_ext);
      a_sq    <= tm_sq[g];
      a_odd   <= tm_odd[g];
    end

    // Stage B: recombine and round to Q.30
    assign prod = (PROD_W'(a_pp_hi) << SQ_LO_W) + PROD_W'(a_pp_lo)
                + (PROD_W'(1) << (Q30_SHIFT - 1));

    always_ff @(posedge clk) begin
      if (rst) begin
        b_vld <= 1'b0;
      end else begin
        b_vld <= a_vld;
      end
      b_n   <= prod[Q30_SHIFT +: N_W];
      b_sum <= a_sum;
      b_sq  <= a_sq;
      b_odd <= a_odd;
    end

    // Stage C: exact division by 2i(2i-1) as a product with the rounded-up reciprocal
    always_ff @(posedge clk) begin
      if (rst) begin
        c_vld <= 1'b0;
      end else begin
        c_vld <= b_vld;
      end
      c_pp_lo <= RPP_W'(b_n) * RPP_W'(RECIP[RECIP_LO_W-1:0]);
      c_pp_hi <= RPP_W'(b_n) * RPP_W'(RECIP[RECIP_W-1:RECIP_LO_W]);
      c_sum   <= b_sum;
      c_sq    <= b_sq;
      c_odd   <= b_odd;
    end

    // Stage D: recombine and shift down to the new term
    assign rprod = (RPROD_W'(c_pp_hi) << RECIP_LO_W) + RPROD_W'(c_pp_lo);

    always_ff @(posedge clk) begin
      if (rst) begin
        tm_vld[g+1] <= 1'b0;
      end else begin
        tm_vld[g+1] <= c_vld;
      end
      tm_term[g+1] <= rprod[RECIP_SHIFT +: TERM_W];
      tm_sum[g+1]  <= c_sum;
      tm_sq[g+1]   <= c_sq;
      tm_odd[g+1]  <= c_odd;
    end
  end

  // Last term joins the sum
  logic signed [SUM_W-1:0] last_ext;
  logic                    fin_vld;
  logic signed [SUM_W-1:0] fin_sum;
  logic                    fin_odd;

  assign last_ext = $signed({{(SUM_W-TERM_W){1'b0}}, tm_term[TERMS]});

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_vld <= 1'b0;
    end else begin
      fin_vld <= tm_vld[TERMS];
    end
    fin_sum <= LAST_SUB ? (tm_sum[TERMS] - last_ext) : (tm_sum[TERMS] + last_ext);
    fin_odd <= tm_odd[TERMS];
  end

  // Sign from the quotient parity, then saturation to Q2.30
  logic signed [SUM_W-1:0]   res_signed;
  logic [SUM_W-VALUE_W:0]    res_top;
  logic signed [VALUE_W-1:0] res_sat;

  always_comb begin
    res_signed = fin_odd ? -fin_sum : fin_sum;
    res_top    = res_signed[SUM_W-1:VALUE_W-1];
    if ((&res_top) || !(|res_top)) begin
      res_sat = res_signed[VALUE_W-1:0];
    end else if (res_signed[SUM_W-1]) begin
      res_sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin_vld;
    end
    value <= res_sat;
  end

  // Every item started comes out after the fixed latency, and nothing else does
  assert property (@(posedge clk) disable iff (rst) accept |-> ##LATENCY done)
    else $error("started item did not complete after the pipeline latency");

  assert property (@(posedge clk) disable iff (rst) done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching started item");

  // Remainder of the reduction is below pi and the quotient within the angle range
  assert property (@(posedge clk) disable iff (rst)
    dv_vld[DIV_STAGES] |-> (dv_rem[DIV_STAGES] < MAG_W'(PI_Q32))
                           && (dv_q[DIV_STAGES] <= Q_W'(40)))
    else $error("angle reduction left a remainder of pi or more");

  // The first series term is exactly x^2 / 2
  assert property (@(posedge clk) disable iff (rst)
    tm_vld[1] |-> (tm_term[1] == TERM_W'(tm_sq[1] >> 1)))
    else $error("first series term differs from x^2 / 2");

endmodule

`default_nettype wire

### verif/taylor_sine_cosine_tb.sv
// Self-checking testbench for the pipelined Taylor-series sine/cosine block.
`timescale 1ns / 1ps

module taylor_sine_cosine_tb;

  localparam int TERMS   = tsc_pkg::TERMS_DEFAULT;
  localparam int LATENCY = 11 + 4 * TERMS;

  // pi in Q8.24 (rounded) for directed angles; pi in Q.32 for the reduction
  localparam logic signed [31:0] PI_Q24   = 32'sd52707179;
  localparam longint             PI_Q32_L = longint'(tsc_pkg::PI_Q32);
  localparam longint             ANG_MAX  = 64'sd2147483647;
  localparam longint             ANG_MIN  = -64'sd2147483648;

  typedef longint unsigned u64_t;

  typedef enum logic {
    OP_COS = 1'b0,
    OP_SIN = 1'b1
  } trig_op_t;

  typedef struct {
    trig_op_t          op;
    logic signed [31:0] ang;
    logic signed [31:0] val;
  } trig_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic operation = OP_COS;
  logic signed [31:0] angle = '0;
  logic busy;
  logic done;
  logic signed [31:0] value;

  trig_result_t pending_values[$];
  int mismatches = 0;
  bit no_gaps = 1'b0;

  taylor_sine_cosine #(.TERMS(TERMS)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .angle     (angle),
    .busy      (busy),
    .done      (done),
    .value     (value)
  );

  always #2 clk = ~clk;

  // Run limit, well above the slowest legal run
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point cosine/sine predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(longint v);
    if (v > ANG_MAX) return ANG_MAX;
    if (v < ANG_MIN) return ANG_MIN;
    return v;
  endfunction

  // Unsigned Q.30 product, rounded to nearest
  function automatic u64_t round_q30(u64_t a, u64_t b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << 29);
    return p[93:30];
  endfunction

  function automatic logic signed [31:0] cos_sin_value(trig_op_t op,
                                                       logic signed [31:0] ang_in);
    longint ang, a32, quo, rem, sum;
    u64_t mag, x30, sq, term, den;
    ang = longint'(ang_in);
    // sine is cos(pi/2 - angle), argument clipped to Q8.24
    if (op == OP_SIN) ang = clamp32(longint'(tsc_pkg::HALF_PI_Q24) - ang);
    // reduce by whole multiples of pi, quotient truncated toward zero
    a32 = ang * 256;
    quo = a32 / PI_Q32_L;
    rem = a32 - quo * PI_Q32_L;
    mag = (rem < 0) ? u64_t'(-rem) : u64_t'(rem);
    x30 = (mag + 2) >> 2;
    sq  = round_q30(x30, x30);
    term = u64_t'(1) << 30;
    sum  = 64'sd1 << 30;
    for (int i = 1; i <= TERMS; i++) begin
      den  = u64_t'(2 * i * (2 * i - 1));
      term = round_q30(term, sq) / den;
      if (i % 2 == 1) sum -= longint'(term);
      else            sum += longint'(term);
    end
    // odd multiple of pi flips the sign
    if (quo[0]) sum = -sum;
    return 32'(clamp32(sum));
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Each result lives for one cycle only; take it at the edge that ends it
  always @(posedge clk) begin
    trig_result_t exp_item;
    if (!rst && done) begin
      if (pending_values.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h", value));
      end else begin
        exp_item = pending_values.pop_front();
        if (value !== exp_item.val)
          report_mismatch($sformatf("%s angle=%h value=%h expected=%h",
                                    exp_item.op.name(), exp_item.ang, value, exp_item.val));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drives one item and returns at the edge that accepts it; start stays high
  task automatic send_item(trig_op_t op, logic signed [31:0] ang);
    trig_result_t item;
    start     <= 1'b1;
    operation <= op;
    angle     <= ang;
    do @(posedge clk); while (busy);
    item.op  = op;
    item.ang = ang;
    item.val = cos_sin_value(op, ang);
    pending_values.push_back(item);
  endtask

  // Random sender gap, with junk on the data ports while start is low;
  // each further idle cycle follows with the same odds
  task automatic maybe_idle();
    while (!no_gaps && $urandom_range(0, 99) < 35) begin
      start     <= 1'b0;
      operation <= 1'($urandom_range(0, 1));
      angle     <= $urandom;
      @(posedge clk);
    end
  endtask

  // Stops sending and waits for every outstanding result, bounded
  task automatic wait_for_results();
    int cycles;
    cycles = 0;
    start <= 1'b0;
    while (pending_values.size() != 0 && cycles < 4 * LATENCY + 20) begin
      @(negedge clk);
      cycles++;
    end
    if (pending_values.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_values.size()));
    pending_values.delete();
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] random_angle(trig_op_t op);
    longint base;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 3) begin
      return $urandom;
    end else if (sel <= 6) begin
      // everyday angles, a few turns either way
      return $signed($urandom) >>> $urandom_range(3, 8);
    end else if (sel <= 8) begin
      // close to a multiple of pi, where the quotient steps
      base = ($signed($urandom_range(0, 80)) - 40) * PI_Q32_L / 256;
      base = base + $signed($urandom_range(0, 64)) - 32;
      if (op == OP_SIN) base = longint'(tsc_pkg::HALF_PI_Q24) - base;
      return 32'(clamp32(base));
    end else begin
      // hugging the ends of the Q8.24 range
      if ($urandom_range(0, 1)) return 32'sh7fffffff - $urandom_range(0, 255);
      return 32'sh80000000 + $urandom_range(0, 255);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset();
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // Cosine: zero, unit steps, multiples of pi and pi/2, both range ends and alternating bit patterns
  task automatic test_cosine_edges();
    send_item(OP_COS, 32'sd0);
    send_item(OP_COS, 32'sd1);
    send_item(OP_COS, -32'sd1);
    send_item(OP_COS, 32'sd16777216);
    send_item(OP_COS, tsc_pkg::HALF_PI_Q24);
    send_item(OP_COS, PI_Q24);
    send_item(OP_COS, PI_Q24 - 32'sd1);
    send_item(OP_COS, -PI_Q24);
    send_item(OP_COS, 32'sd79060768);
    send_item(OP_COS, 32'sd105414357);
    send_item(OP_COS, 32'sh7fffffff);
    send_item(OP_COS, 32'sh80000000);
    send_item(OP_COS, 32'sh55555555);
    send_item(OP_COS, 32'shaaaaaaaa);
  endtask

  // Sine: plain angles and the clip of pi/2 - angle at both sides of the limit
  task automatic test_sine_edges();
    send_item(OP_SIN, 32'sd0);
    send_item(OP_SIN, tsc_pkg::HALF_PI_Q24);
    send_item(OP_SIN, PI_Q24);
    send_item(OP_SIN, -tsc_pkg::HALF_PI_Q24);
    send_item(OP_SIN, 32'sh7fffffff);
    send_item(OP_SIN, 32'sh80000000);
    send_item(OP_SIN, tsc_pkg::HALF_PI_Q24 - 32'sh7fffffff);
    send_item(OP_SIN, tsc_pkg::HALF_PI_Q24 - 32'sh7fffffff - 32'sd1);
    send_item(OP_SIN, 32'shaaaaaaaa);
    send_item(OP_SIN, 32'sh55555555);
    wait_for_results();
  endtask

  // One item every cycle, no gaps at all
  task automatic test_back_to_back(int count);
    trig_op_t op;
    no_gaps = 1'b1;
    for (int n = 0; n < count; n++) begin
      op = trig_op_t'($urandom_range(0, 1));
      send_item(op, random_angle(op));
    end
    no_gaps = 1'b0;
  endtask

  // Sender holds off until the pipe has emptied, then carries on
  task automatic test_drain_pause();
    trig_op_t op;
    for (int n = 0; n < 30; n++) begin
      op = trig_op_t'($urandom_range(0, 1));
      send_item(op, random_angle(op));
      maybe_idle();
    end
    wait_for_results();
    for (int n = 0; n < 10; n++) begin
      op = trig_op_t'($urandom_range(0, 1));
      send_item(op, random_angle(op));
    end
  endtask

  // Random items with random sender gaps
  task automatic test_random_mixed(int count);
    trig_op_t op;
    for (int n = 0; n < count; n++) begin
      op = trig_op_t'($urandom_range(0, 1));
      send_item(op, random_angle(op));
      maybe_idle();
    end
  endtask

  initial begin
    test_reset();
    test_cosine_edges();
    test_sine_edges();
    test_back_to_back(300);
    test_drain_pause();
    test_random_mixed(1250);
    wait_for_results();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### taylor_sine_cosine.f
hdl/tsc_pkg.sv
hdl/taylor_sine_cosine.sv
verif/taylor_sine_cosine_tb.sv
